// ===== rtl/core/rbfg_pkg.sv =====
// Shared constants, codes, cell record and helper arithmetic of the block feature grid.
package rbfg_pkg;

    // Default geometry
    localparam int RBFG_GRID_SIZE = 64;
    localparam int RBFG_MAX_DIM   = 4096;

    // Configuration port
    localparam int RBFG_CFG_W   = 13;
    localparam int RBFG_IDX_W   = 2;
    localparam logic [RBFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [RBFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Class codes
    localparam logic [1:0] FLOW_NONE       = 2'd0;
    localparam logic [1:0] FLOW_HORIZONTAL = 2'd1;
    localparam logic [1:0] FLOW_VERTICAL   = 2'd2;
    localparam logic [1:0] FLOW_DIAGONAL   = 2'd3;
    localparam logic [1:0] MOOD_WARM       = 2'd0;
    localparam logic [1:0] MOOD_COOL       = 2'd1;
    localparam logic [1:0] MOOD_DRAMATIC   = 2'd2;
    localparam logic [1:0] MOOD_NEUTRAL    = 2'd3;
    localparam logic [1:0] DEPTH_BACK      = 2'd0;
    localparam logic [1:0] DEPTH_MID       = 2'd1;
    localparam logic [1:0] DEPTH_FORE      = 2'd2;

    // Thresholds of the classifiers
    localparam int FLOW_FLOOR    = 5;
    localparam int MOOD_SPREAD   = 20;
    localparam int MOOD_DARK     = 80;

    // One finished cell
    typedef struct packed {
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic [7:0] intensity;
        logic [1:0] flow_class;
        logic [1:0] mood_class;
        logic [1:0] depth_band;
        logic       frame_done;
    } t_cell;

    // Divider handshake toward its user
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // floor(v/3) for v up to 765, by reciprocal
    function automatic logic [7:0] div3_u10(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd683;
        return p[18:11];
    endfunction

    // floor(v/5) for v below 2048, by reciprocal
    function automatic logic [8:0] div5_u11(input logic [10:0] v);
        logic [23:0] p;
        p = 24'(v) * 24'd1639;
        return p[21:13];
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/core/rbfg_if.sv =====
// Pixel and cell stream interfaces of the block feature grid.
interface rbfg_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rbfg_cell_if;
    logic       valid;
    logic       ready;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [7:0] intensity;
    logic [1:0] flow_class;
    logic [1:0] mood_class;
    logic [1:0] depth_band;
    logic       frame_done;
    modport source (output valid, output cell_row, output cell_col, output intensity,
                    output flow_class, output mood_class, output depth_band,
                    output frame_done, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input intensity,
                    input flow_class, input mood_class, input depth_band,
                    input frame_done, output ready);
endinterface

// ===== rtl/core/rgb_block_feature_grid.sv =====
// Top level of the block feature grid: position tracking, column memory sequencer, classifiers.
//
//  channel   dir  handshake           payload
//  i_pix     in   valid/ready         red, green, blue (8 bits each)
//  o_cell    out  valid/ready         cell_row, cell_col, intensity, flow/mood/depth, frame_done
//  i_cfg     in   i_cfg_we            i_cfg_idx, i_cfg_data (13 bits)
//
// A pixel inside a block row span passes accept, memory read and write back.
// A pixel closing a row span adds the span mean on the shared divider;
// a pixel closing a block adds the five cell means on it as well, plus the wait
// for the output register. One pixel is in work at a time.
// Reset and each write of frame width or height clear the column memory at once through its valid bits.
// A stalled output holds the finished cell; the next pixel is still taken meanwhile.
module rgb_block_feature_grid
    import rbfg_pkg::*;
#(
    parameter int GRID_SIZE = RBFG_GRID_SIZE,
    parameter int MAX_DIM   = RBFG_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbfg_pix_if.sink              i_pix,
    rbfg_cell_if.source           o_cell,
    input  logic                  i_cfg_we,
    input  logic [RBFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RBFG_CFG_W-1:0] i_cfg_data
);
    localparam int MAXD    = (MAX_DIM >= GRID_SIZE) ? MAX_DIM : GRID_SIZE;
    localparam int BD      = (MAXD + GRID_SIZE - 1) / GRID_SIZE;
    localparam int SW      = $clog2(255 * BD * BD + 1);
    localparam int PCW     = $clog2(BD * BD + 1);
    localparam int RSW     = $clog2(255 * BD + 1);
    localparam int RCW     = $clog2(BD + 1);
    localparam int GW      = $clog2(GRID_SIZE);
    localparam int DW      = $clog2(MAXD + 1);
    localparam int PW      = $clog2((GRID_SIZE + 2) * (MAXD + 2));
    localparam int RST_DIM = (64 < GRID_SIZE) ? GRID_SIZE : ((64 > MAXD) ? MAXD : 64);
    localparam int TH1     = GRID_SIZE / 3;
    localparam int TH2     = GRID_SIZE * 2 / 3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_DROW  = 3'd2;
    localparam logic [2:0] S_DCELL = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [2:0] JOB_RED   = 3'd0;
    localparam logic [2:0] JOB_GREEN = 3'd1;
    localparam logic [2:0] JOB_BLUE  = 3'd2;
    localparam logic [2:0] JOB_HGRAD = 3'd3;
    localparam logic [2:0] JOB_VGRAD = 3'd4;

    typedef struct packed {
        logic [SW-1:0]  rsum;
        logic [SW-1:0]  gsum;
        logic [SW-1:0]  bsum;
        logic [PCW-1:0] pcnt;
        logic [SW-1:0]  hsum;
        logic [PCW-1:0] hcnt;
        logic [RSW-1:0] vsum;
        logic [RCW-1:0] vcnt;
        logic [7:0]     pmean;
        logic           pvalid;
        logic [RSW-1:0] lsum;
        logic [RCW-1:0] lcnt;
    } t_col;

    logic [2:0]    r_state, n_state;
    logic [DW-1:0] r_fw, n_fw, r_fh, n_fh;
    logic [DW-1:0] r_px, n_px, r_py, n_py;
    logic [GW:0]   r_bc, n_bc, r_br, n_br;
    logic [PW-1:0] r_prx, n_prx, r_pry, n_pry, r_tx, n_tx, r_ty, n_ty;
    logic          r_pcv, n_pcv;
    logic [7:0]    r_pcl, n_pcl;
    logic [7:0]    r_r, n_r, r_g, n_g, r_b, n_b, r_lum, n_lum;
    t_col          r_w, n_w;
    logic [2:0]    r_job, n_job;
    logic [7:0]    r_mq [5];
    logic [7:0]    n_mq [5];
    t_cell         r_out, n_out;
    logic          r_ov, n_ov;

    t_col          rd, upd, w2;
    logic [GW-1:0] col;
    logic          xe, ye, wrap, adv, restart;
    logic          ram_we, ram_re, ram_clear;
    t_col          ram_wdata;
    logic          div_start;
    logic [SW-1:0] div_num;
    logic [PCW-1:0] div_den;
    logic [2:0]    jsel;
    t_div_stat     div_stat;
    logic [7:0]    div_q;
    logic [DW-1:0] cfg_dim;
    logic [31:0]   cfg_v;
    t_cell         cell_cls;
    logic [9:0]    sum3;
    logic [10:0]   gx6, gy6;
    logic [8:0]    gx65, gy65;
    logic signed [9:0] dmood;
    logic [8:0]    rb_sum;

    // Column memory
    rbfg_col_ram #(.DATA_W($bits(t_col)), .DEPTH(GRID_SIZE)) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (ram_clear),
        .i_we    (ram_we),
        .i_waddr (col),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (col),
        .o_rdata (rd)
    );

    // Shared divider for span and cell means
    rbfg_divider #(.NUM_W(SW), .DEN_W(PCW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_q)
    );

    // Column in work and edge tests
    assign col  = (r_bc >= (GW+1)'(GRID_SIZE)) ? GW'(GRID_SIZE - 1) : r_bc[GW-1:0];
    assign xe   = r_prx < r_tx;
    assign ye   = r_pry < r_ty;
    assign wrap = ({1'b0, r_px} + 1'b1) >= {1'b0, r_fw};

    // Saturate a written dimension
    assign cfg_v   = 32'(i_cfg_data);
    assign cfg_dim = (cfg_v < 32'(GRID_SIZE)) ? DW'(GRID_SIZE) :
                     (cfg_v > 32'(MAXD)) ? DW'(MAXD) : DW'(cfg_v);

    // Accumulate one pixel into the column word
    always_comb begin
        upd      = rd;
        upd.rsum = rd.rsum + SW'(r_r);
        upd.gsum = rd.gsum + SW'(r_g);
        upd.bsum = rd.bsum + SW'(r_b);
        upd.pcnt = rd.pcnt + 1'b1;
        if (r_pcv) begin
            upd.hsum = rd.hsum + SW'(absdiff8(r_lum, r_pcl));
            upd.hcnt = rd.hcnt + 1'b1;
        end
        upd.lsum = rd.lsum + RSW'(r_lum);
        upd.lcnt = rd.lcnt + 1'b1;
    end

    // Close the row span with its mean
    always_comb begin
        w2 = r_w;
        if (r_w.pvalid) begin
            w2.vsum = r_w.vsum + RSW'(absdiff8(div_q, r_w.pmean));
            w2.vcnt = r_w.vcnt + 1'b1;
        end
        w2.pmean  = div_q;
        w2.pvalid = 1'b1;
        w2.lsum   = '0;
        w2.lcnt   = '0;
    end

    // Classify the finished cell
    always_comb begin
        sum3  = 10'(r_mq[JOB_RED]) + 10'(r_mq[JOB_GREEN]) + 10'(r_mq[JOB_BLUE]);
        gx6   = 11'(r_mq[JOB_HGRAD]) * 11'd6;
        gy6   = 11'(r_mq[JOB_VGRAD]) * 11'd6;
        gx65  = div5_u11(gx6);
        gy65  = div5_u11(gy6);
        dmood = $signed({2'b00, r_mq[JOB_RED]}) - $signed({2'b00, r_mq[JOB_BLUE]});
        rb_sum = 9'(r_mq[JOB_RED]) + 9'(r_mq[JOB_BLUE]);
        cell_cls.cell_row  = 6'(r_br);
        cell_cls.cell_col  = 6'(col);
        cell_cls.intensity = div3_u10(sum3);
        if (r_mq[JOB_HGRAD] < 8'(FLOW_FLOOR) && r_mq[JOB_VGRAD] < 8'(FLOW_FLOOR)) begin
            cell_cls.flow_class = FLOW_NONE;
        end else if (9'(r_mq[JOB_HGRAD]) > gy65) begin
            cell_cls.flow_class = FLOW_HORIZONTAL;
        end else if (9'(r_mq[JOB_VGRAD]) > gx65) begin
            cell_cls.flow_class = FLOW_VERTICAL;
        end else begin
            cell_cls.flow_class = FLOW_DIAGONAL;
        end
        if (dmood > 10'sd20) begin
            cell_cls.mood_class = MOOD_WARM;
        end else if (dmood < -10'sd20) begin
            cell_cls.mood_class = MOOD_COOL;
        end else if (rb_sum[8:1] < 8'(MOOD_DARK)) begin
            cell_cls.mood_class = MOOD_DRAMATIC;
        end else begin
            cell_cls.mood_class = MOOD_NEUTRAL;
        end
        if (r_br < (GW+1)'(TH1)) begin
            cell_cls.depth_band = DEPTH_BACK;
        end else if (r_br < (GW+1)'(TH2)) begin
            cell_cls.depth_band = DEPTH_MID;
        end else begin
            cell_cls.depth_band = DEPTH_FORE;
        end
        cell_cls.frame_done = (col == GW'(GRID_SIZE - 1)) && (r_br >= (GW+1)'(GRID_SIZE - 1));
    end

    // Sequencer, position tracking and configuration
    always_comb begin
        n_state = r_state;
        n_fw = r_fw;   n_fh = r_fh;
        n_px = r_px;   n_py = r_py;
        n_bc = r_bc;   n_br = r_br;
        n_prx = r_prx; n_pry = r_pry;
        n_tx = r_tx;   n_ty = r_ty;
        n_pcv = r_pcv; n_pcl = r_pcl;
        n_r = r_r; n_g = r_g; n_b = r_b; n_lum = r_lum;
        n_w = r_w;
        n_job = r_job;
        n_mq = r_mq;
        n_out = r_out;
        n_ov = r_ov;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_clear = 1'b0;
        ram_wdata = r_w;
        div_start = 1'b0;
        jsel = r_job + 1'b1;
        adv = 1'b0;
        restart = 1'b0;

        // Retire the delivered cell
        if (r_ov && o_cell.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_r   = i_pix.red;
                    n_g   = i_pix.green;
                    n_b   = i_pix.blue;
                    n_lum = div3_u10(10'(i_pix.red) + 10'(i_pix.green) + 10'(i_pix.blue));
                    ram_re  = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_w = upd;
                if (xe) begin
                    div_start = 1'b1;
                    n_state   = S_DROW;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DROW: begin
                if (div_stat.done) begin
                    n_w = w2;
                    if (ye) begin
                        div_start = 1'b1;
                        jsel      = JOB_RED;
                        n_job     = JOB_RED;
                        n_state   = S_DCELL;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end
            S_DCELL: begin
                if (div_stat.done) begin
                    n_mq[r_job] = div_q;
                    if (r_job == JOB_VGRAD) begin
                        n_state = S_EMIT;
                    end else begin
                        div_start = 1'b1;
                        n_job     = r_job + 1'b1;
                    end
                end
            end
            S_WB: begin
                ram_we  = 1'b1;
                adv     = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (!r_ov || o_cell.ready) begin
                    n_out     = cell_cls;
                    n_ov      = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    adv       = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance the raster position
        if (adv) begin
            n_pcv = !(xe || wrap);
            n_pcl = r_lum;
            if (xe) begin
                n_bc  = r_bc + 1'b1;
                n_prx = r_prx + PW'(r_fw);
            end
            n_px = r_px + 1'b1;
            n_tx = r_tx + PW'(GRID_SIZE);
            if (wrap) begin
                n_px  = '0;
                n_bc  = '0;
                n_prx = PW'(r_fw);
                n_tx  = PW'(2 * GRID_SIZE);
                n_py  = r_py + 1'b1;
                n_ty  = r_ty + PW'(GRID_SIZE);
                if (ye) begin
                    n_br  = r_br + 1'b1;
                    n_pry = r_pry + PW'(r_fh);
                end
                if (({1'b0, r_py} + 1'b1) >= {1'b0, r_fh}) begin
                    restart = 1'b1;
                end
            end
        end

        // Writes of frame width or height restart the frame
        if (i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH)) begin
            n_fw    = cfg_dim;
            restart = 1'b1;
        end else if (i_cfg_we && (i_cfg_idx == REG_FRAME_HEIGHT)) begin
            n_fh    = cfg_dim;
            restart = 1'b1;
        end

        if (restart) begin
            ram_clear = 1'b1;
            n_px  = '0;
            n_py  = '0;
            n_bc  = '0;
            n_br  = '0;
            n_prx = PW'(n_fw);
            n_pry = PW'(n_fh);
            n_tx  = PW'(2 * GRID_SIZE);
            n_ty  = PW'(2 * GRID_SIZE);
            n_pcv = 1'b0;
        end
    end

    // Divider operands: span mean first, then the cell means
    always_comb begin
        if (r_state == S_UPD) begin
            div_num = SW'(upd.lsum);
            div_den = PCW'(upd.lcnt);
        end else begin
            case (jsel)
                JOB_RED:   begin div_num = r_w.rsum;      div_den = r_w.pcnt;       end
                JOB_GREEN: begin div_num = r_w.gsum;      div_den = r_w.pcnt;       end
                JOB_BLUE:  begin div_num = r_w.bsum;      div_den = r_w.pcnt;       end
                JOB_HGRAD: begin div_num = r_w.hsum;      div_den = r_w.hcnt;       end
                JOB_VGRAD: begin div_num = SW'(r_w.vsum); div_den = PCW'(r_w.vcnt); end
                default:   begin div_num = '0;            div_den = '0;             end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fw    <= DW'(RST_DIM);
            r_fh    <= DW'(RST_DIM);
            r_px    <= '0;
            r_py    <= '0;
            r_bc    <= '0;
            r_br    <= '0;
            r_prx   <= PW'(RST_DIM);
            r_pry   <= PW'(RST_DIM);
            r_tx    <= PW'(2 * GRID_SIZE);
            r_ty    <= PW'(2 * GRID_SIZE);
            r_pcv   <= 1'b0;
            r_job   <= JOB_RED;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fw    <= n_fw;
            r_fh    <= n_fh;
            r_px    <= n_px;
            r_py    <= n_py;
            r_bc    <= n_bc;
            r_br    <= n_br;
            r_prx   <= n_prx;
            r_pry   <= n_pry;
            r_tx    <= n_tx;
            r_ty    <= n_ty;
            r_pcv   <= n_pcv;
            r_job   <= n_job;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pcl <= n_pcl;
        r_r   <= n_r;
        r_g   <= n_g;
        r_b   <= n_b;
        r_lum <= n_lum;
        r_w   <= n_w;
        r_mq  <= n_mq;
        r_out <= n_out;
    end

    // Ports
    assign i_pix.ready        = (r_state == S_IDLE);
    assign o_cell.valid       = r_ov;
    assign o_cell.cell_row    = r_out.cell_row;
    assign o_cell.cell_col    = r_out.cell_col;
    assign o_cell.intensity   = r_out.intensity;
    assign o_cell.flow_class  = r_out.flow_class;
    assign o_cell.mood_class  = r_out.mood_class;
    assign o_cell.depth_band  = r_out.depth_band;
    assign o_cell.frame_done  = r_out.frame_done;
endmodule

// ===== rtl/core/rbfg_col_ram.sv =====
// Per-column accumulator memory with registered read and per-entry valid bits.
module rbfg_col_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd;
    logic              r_rv;

    // Write and read the storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    // Track written entries; clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rv <= r_valid[i_raddr];
            end
        end
    end

    // Unwritten entries read as zero
    assign o_rdata = r_rv ? r_rd : '0;
endmodule

// ===== rtl/core/rbfg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, zero on a zero divisor.
module rbfg_divider
    import rbfg_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [7:0]       o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Control: count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: shift, compare, subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_zero ? 8'd0 : r_q[7:0];
endmodule

// ===== rtl/core/rbfg_checker.sv =====
// Port-level assertions of the block feature grid and their binding to the top level.
module rbfg_checker
    import rbfg_pkg::*;
#(
    parameter int GRID_SIZE = RBFG_GRID_SIZE
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pix_valid,
    input logic        i_pix_ready,
    input logic        i_cell_valid,
    input logic        i_cell_ready,
    input logic [26:0] i_cell_payload,
    input logic [5:0]  i_cell_row,
    input logic [5:0]  i_cell_col,
    input logic [1:0]  i_depth_band,
    input logic        i_frame_done
);
    // Hold a stalled request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell_valid && !i_cell_ready |=> i_cell_valid && $stable(i_cell_payload))
        else $error("stalled cell request changed");

    // No result right out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_cell_valid)
        else $error("cell valid after reset");

    // One pixel in work at a time
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> !i_pix_ready)
        else $error("pixel taken while another is in work");

    // Frame end sits on the last grid cell
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell_valid && i_frame_done |->
            i_cell_row == 6'(GRID_SIZE - 1) && i_cell_col == 6'(GRID_SIZE - 1)
            && i_depth_band == DEPTH_FORE)
        else $error("frame end off the last cell");
endmodule

bind rgb_block_feature_grid rbfg_checker #(.GRID_SIZE(GRID_SIZE)) u_rbfg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pix_valid    (i_pix.valid),
    .i_pix_ready    (i_pix.ready),
    .i_cell_valid   (o_cell.valid),
    .i_cell_ready   (o_cell.ready),
    .i_cell_payload ({o_cell.cell_row, o_cell.cell_col, o_cell.intensity,
                      o_cell.flow_class, o_cell.mood_class, o_cell.depth_band,
                      o_cell.frame_done}),
    .i_cell_row     (o_cell.cell_row),
    .i_cell_col     (o_cell.cell_col),
    .i_depth_band   (o_cell.depth_band),
    .i_frame_done   (o_cell.frame_done)
);
